FILE: rtl/ste_pkg.sv
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types and constants for the session table with expiry.
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int KEY_W     = 64;
  localparam int TIME_W    = 48;
  localparam int TIMEOUT_W = 27;
  localparam int OP_W      = 2;
  localparam int SLOT_W    = 3;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(900000);
  localparam logic [TIME_W-1:0]    TIME_MAX      = '1;

  // request codes
  localparam logic [OP_W-1:0] OP_LOGIN      = 2'd0;
  localparam logic [OP_W-1:0] OP_VALIDATE   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOGOUT     = 2'd2;
  localparam logic [OP_W-1:0] OP_LOGOUT_ALL = 2'd3;

  // register index of the timeout register
  localparam logic [0:0] REG_TIMEOUT = 1'b0;

  // flags from the shared compare unit for one table entry
  typedef struct packed {
    logic key_eq;   // stored key equals request key
    logic expired;  // now is at or past the stored deadline
    logic earlier;  // stored deadline is below the running minimum
  } cmp_res_t;

endpackage

FILE: rtl/ste_ram.sv
// ----------------------------------------------------------------------------
// ste_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ste_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/ste_cmp.sv
// ----------------------------------------------------------------------------
// ste_cmp
// Shared compare unit: key match, expiry check and deadline minimum check
// for the one table entry being scanned this cycle.
// ----------------------------------------------------------------------------
module ste_cmp (
  input  logic [ste_pkg::KEY_W-1:0]  ent_key_high,
  input  logic [ste_pkg::KEY_W-1:0]  ent_key_low,
  input  logic [ste_pkg::TIME_W-1:0] ent_deadline,
  input  logic [ste_pkg::KEY_W-1:0]  req_key_high,
  input  logic [ste_pkg::KEY_W-1:0]  req_key_low,
  input  logic [ste_pkg::TIME_W-1:0] req_now,
  input  logic [ste_pkg::TIME_W-1:0] min_deadline,
  output ste_pkg::cmp_res_t          res
);
  import ste_pkg::*;

  always_comb begin
    res.key_eq  = (ent_key_high == req_key_high) && (ent_key_low == req_key_low);
    res.expired = (req_now >= ent_deadline);
    res.earlier = (ent_deadline < min_deadline);
  end

endmodule

FILE: rtl/session_table_with_expiry.sv
// ----------------------------------------------------------------------------
// session_table_with_expiry
// Table of 128-bit session keys with deadlines. Login, validate and logout
// requests are served by one entry scan through a shared compare unit,
// followed by a single write-back; logout-all clears every entry at once.
//
//   channel   direction  handshake             payload
//   in_*      input      in_valid / in_stall   op, key_high, key_low, now_ms
//   out_*     output     out_valid / out_stall found, slot, evicted
//   APB       input      psel / penable        timeout_ms at byte address 0
//
// A request is captured, then scanned with one RAM read per entry, written
// back, and its result loaded into the output register once that is free.
// Logout-all skips the scan and write-back.
// The entry RAM has one read port, which sets the scan length.
// Reset clears every valid bit and loads the default timeout; the RAM needs
// no clearing. A new request is taken while a result still waits on out_stall.
// ----------------------------------------------------------------------------
module session_table_with_expiry #(
  parameter int NUM_ENTRIES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ste_pkg::OP_W-1:0]      in_op,
  input  logic [ste_pkg::KEY_W-1:0]     in_key_high,
  input  logic [ste_pkg::KEY_W-1:0]     in_key_low,
  input  logic [ste_pkg::TIME_W-1:0]    in_now_ms,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [ste_pkg::SLOT_W-1:0]    out_slot,
  output logic                          out_evicted,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ste_pkg::APB_AW-1:0]    paddr,
  input  logic [ste_pkg::APB_DW-1:0]    pwdata,
  output logic [ste_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import ste_pkg::*;

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int ENT_W = 2 * KEY_W + TIME_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // control
  logic [1:0]             state_r, state_nxt;
  logic [NUM_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]       iss_r, iss_nxt;
  logic                   iss_done_r, iss_done_nxt;
  logic                   chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                   have_r, have_nxt;
  logic                   min_have_r, min_have_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [TIMEOUT_W-1:0]   timeout_r;

  // payload
  logic [OP_W-1:0]        op_r, op_nxt;
  logic [KEY_W-1:0]       key_h_r, key_h_nxt;
  logic [KEY_W-1:0]       key_l_r, key_l_nxt;
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [TIME_W-1:0]      dl_new_r, dl_new_nxt;
  logic [IDX_W-1:0]       pick_r, pick_nxt;
  logic [TIME_W-1:0]      min_dl_r, min_dl_nxt;
  logic [IDX_W-1:0]       min_idx_r, min_idx_nxt;
  logic                   res_found_r, res_found_nxt;
  logic [IDX_W-1:0]       res_idx_r, res_idx_nxt;
  logic                   res_evict_r, res_evict_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic                   out_evict_r, out_evict_nxt;

  logic                   in_acc;
  logic                   cfg_wr;
  logic [TIME_W:0]        dl_sum;
  logic [TIME_W-1:0]      dl_sat;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENT_W-1:0]       ram_wdata;
  logic [ENT_W-1:0]       ram_rdata;
  logic [KEY_W-1:0]       ent_key_h;
  logic [KEY_W-1:0]       ent_key_l;
  logic [TIME_W-1:0]      ent_dl;
  cmp_res_t               cmp;
  logic                   purge_op;
  logic                   ent_live;
  logic [IDX_W-1:0]       tgt;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[APB_AW-1] == REG_TIMEOUT);
  assign prdata = (paddr[APB_AW-1] == REG_TIMEOUT) ? APB_DW'(timeout_r) : '0;

  // saturating deadline for the request being captured
  assign dl_sum = {1'b0, in_now_ms} + (TIME_W + 1)'(timeout_r);
  assign dl_sat = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];

  assign {ent_key_h, ent_key_l, ent_dl} = ram_rdata;
  assign ram_wdata = {key_h_r, key_l_r, dl_new_r};

  ste_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (iss_r),
    .rdata (ram_rdata)
  );

  ste_cmp u_cmp (
    .ent_key_high (ent_key_h),
    .ent_key_low  (ent_key_l),
    .ent_deadline (ent_dl),
    .req_key_high (key_h_r),
    .req_key_low  (key_l_r),
    .req_now      (now_r),
    .min_deadline (min_dl_r),
    .res          (cmp)
  );

  assign purge_op = (op_r == OP_LOGIN) || (op_r == OP_VALIDATE);
  assign ent_live = valid_r[chk_idx_r] && !(purge_op && cmp.expired);
  assign tgt      = have_r ? pick_r : min_idx_r;
  assign slot_ext = (IDX_W + SLOT_W)'(res_idx_r);

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    iss_nxt       = iss_r;
    iss_done_nxt  = iss_done_r;
    chk_v_nxt     = 1'b0;
    chk_idx_nxt   = iss_r;
    have_nxt      = have_r;
    min_have_nxt  = min_have_r;
    op_nxt        = op_r;
    key_h_nxt     = key_h_r;
    key_l_nxt     = key_l_r;
    now_nxt       = now_r;
    dl_new_nxt    = dl_new_r;
    pick_nxt      = pick_r;
    min_dl_nxt    = min_dl_r;
    min_idx_nxt   = min_idx_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    res_evict_nxt = res_evict_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_slot_nxt  = out_slot_r;
    out_evict_nxt = out_evict_r;
    ram_we        = 1'b0;
    ram_waddr     = tgt;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_op;
          key_h_nxt    = in_key_high;
          key_l_nxt    = in_key_low;
          now_nxt      = in_now_ms;
          dl_new_nxt   = dl_sat;
          iss_nxt      = '0;
          iss_done_nxt = 1'b0;
          have_nxt     = 1'b0;
          min_have_nxt = 1'b0;
          pick_nxt     = '0;
          min_idx_nxt  = '0;
          if (in_op == OP_LOGOUT_ALL) begin
            valid_nxt     = '0;
            res_found_nxt = 1'b0;
            res_idx_nxt   = '0;
            res_evict_nxt = 1'b0;
            state_nxt     = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue one read a cycle
        if (!iss_done_r) begin
          chk_v_nxt = 1'b1;
          if (iss_r == LAST_IDX) begin
            iss_done_nxt = 1'b1;
          end else begin
            iss_nxt = iss_r + 1'b1;
          end
        end
        // check the entry read last cycle
        if (chk_v_r) begin
          if (purge_op && valid_r[chk_idx_r] && cmp.expired) begin
            valid_nxt[chk_idx_r] = 1'b0;
          end
          if (op_r == OP_LOGIN) begin
            if (!ent_live && !have_r) begin
              have_nxt = 1'b1;
              pick_nxt = chk_idx_r;
            end
            if (ent_live && (!min_have_r || cmp.earlier)) begin
              min_have_nxt = 1'b1;
              min_dl_nxt   = ent_dl;
              min_idx_nxt  = chk_idx_r;
            end
          end else if (ent_live && cmp.key_eq && !have_r) begin
            have_nxt = 1'b1;
            pick_nxt = chk_idx_r;
          end
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        res_evict_nxt = 1'b0;
        res_found_nxt = have_r;
        res_idx_nxt   = pick_r;
        if (op_r == OP_LOGIN) begin
          ram_we          = 1'b1;
          valid_nxt[tgt]  = 1'b1;
          res_found_nxt   = 1'b1;
          res_idx_nxt     = tgt;
          res_evict_nxt   = !have_r;
        end else if (op_r == OP_VALIDATE) begin
          ram_we = have_r;
        end else if (have_r) begin
          valid_nxt[pick_r] = 1'b0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_slot_nxt  = slot_ext[SLOT_W-1:0];
          out_evict_nxt = res_evict_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      iss_r       <= '0;
      iss_done_r  <= 1'b0;
      chk_v_r     <= 1'b0;
      chk_idx_r   <= '0;
      have_r      <= 1'b0;
      min_have_r  <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      iss_r       <= iss_nxt;
      iss_done_r  <= iss_done_nxt;
      chk_v_r     <= chk_v_nxt;
      chk_idx_r   <= chk_idx_nxt;
      have_r      <= have_nxt;
      min_have_r  <= min_have_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        timeout_r <= pwdata[TIMEOUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_h_r     <= key_h_nxt;
    key_l_r     <= key_l_nxt;
    now_r       <= now_nxt;
    dl_new_r    <= dl_new_nxt;
    pick_r      <= pick_nxt;
    min_dl_r    <= min_dl_nxt;
    min_idx_r   <= min_idx_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    res_evict_r <= res_evict_nxt;
    out_found_r <= out_found_nxt;
    out_slot_r  <= out_slot_nxt;
    out_evict_r <= out_evict_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_slot    = out_slot_r;
  assign out_evicted = out_evict_r;

  // an eviction always stores the key
  a_evict_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_evicted || out_found))
    else $error("eviction reported without a stored key");

  // no match reports slot zero
  a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_slot == '0))
    else $error("miss with nonzero slot");

  // write-back follows a scan
  a_write_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> ($past(state_r) == S_SCAN))
    else $error("write-back without a scan");

  // logout-all empties the table at once
  a_logout_all: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == OP_LOGOUT_ALL)) |=> (valid_r == '0))
    else $error("table not empty after logout-all");

  // a login marks its target slot valid
  a_login_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WRITE) && (op_r == OP_LOGIN)) |=> valid_r[$past(tgt)])
    else $error("login slot not valid");

endmodule
